// ===== design/oal_pkg.sv =====
// Package for the ordered array list engine: operation and status codes,
// the per-cell command type and the size constants.
// No dependencies.
`default_nettype none

package oal_pkg;

    // Default number of list cells.
    localparam int OAL_DEPTH = 128;

    // Cells per group in the registered read and search tree.
    localparam int OAL_GROUP      = 16;
    localparam int OAL_GROUP_BITS = 4;

    // Payload widths fixed by the transaction format.
    localparam int OAL_DATA_W  = 32;
    localparam int OAL_POS_W   = 7;
    localparam int OAL_COUNT_W = 8;

    typedef enum logic [2:0] {
        OP_CLEAR  = 3'd0,
        OP_INSERT = 3'd1,
        OP_DELETE = 3'd2,
        OP_SEARCH = 3'd3,
        OP_READ   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_NOTFND = 2'd3
    } status_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic do_insert;
        logic do_delete;
    } cell_cmd_t;

endpackage

`default_nettype wire

// ===== design/oal_req_if.sv =====
// Request channel of the ordered array list engine: valid/ready handshake
// with operation, position and value. Depends on nothing.
`default_nettype none

interface oal_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         op;
    logic [6:0]         position;
    logic signed [31:0] value;

    modport source (output valid, output op, output position, output value, input ready);
    modport sink   (input valid, input op, input position, input value, output ready);
endinterface

`default_nettype wire

// ===== design/oal_rsp_if.sv =====
// Response channel of the ordered array list engine: valid/ready handshake
// with status, data, found position and count. Depends on nothing.
`default_nettype none

interface oal_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] data;
    logic [6:0]         found_position;
    logic [7:0]         count;

    modport source (output valid, output status, output data, output found_position,
                    output count, input ready);
    modport sink   (input valid, input status, input data, input found_position,
                    input count, output ready);
endinterface

`default_nettype wire

// ===== design/oal_cell.sv =====
// One cell of the list chain: holds one entry, shifts it to or takes it from
// its neighbors, and compares it with the search key. Uses oal_pkg.
`default_nettype none

module oal_cell
    import oal_pkg::*;
#(
    parameter int IDX = 0,
    parameter int PW  = 7
)
(
    input  wire logic                  clk,
    input  wire cell_cmd_t             cmd,
    input  wire logic [PW-1:0]         pos,
    input  wire logic signed [31:0]    key,
    input  wire logic signed [31:0]    left_entry,
    input  wire logic signed [31:0]    right_entry,
    output logic signed [31:0]         entry,
    output logic                       match
);

    localparam logic [PW-1:0] IDX_V = PW'(IDX);

    logic signed [31:0] entry_reg;
    logic signed [31:0] entry_next;

    // Insert loads the key at the position and moves later cells up; delete
    // pulls the right neighbor into this cell from the position onward.
    always_comb
    begin
        priority if (cmd.do_insert && (IDX_V == pos))
        begin
            entry_next = key;
        end
        else if (cmd.do_insert && (IDX_V > pos))
        begin
            entry_next = left_entry;
        end
        else if (cmd.do_delete && (IDX_V >= pos))
        begin
            entry_next = right_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    // Entry storage is payload and needs no reset.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign match = (entry_reg == key);

endmodule

`default_nettype wire

// ===== design/oal_group.sv =====
// First level of the registered read and search tree: selects one entry of a
// group of cells and finds the group's first matching cell. Uses oal_pkg.
`default_nettype none

module oal_group
    import oal_pkg::*;
(
    input  wire logic                                clk,
    input  wire logic [OAL_GROUP-1:0][31:0]          ents,
    input  wire logic [OAL_GROUP-1:0]                hits,
    input  wire logic [OAL_GROUP_BITS-1:0]           sel,
    output logic signed [31:0]                       sel_data,
    output logic                                     any_hit,
    output logic [OAL_GROUP_BITS-1:0]                first_hit
);

    logic signed [31:0]          sel_data_reg;
    logic                        any_hit_reg;
    logic [OAL_GROUP_BITS-1:0]   first_hit_reg;
    logic [OAL_GROUP_BITS-1:0]   first_hit_next;

    // Lowest matching cell wins.
    always_comb
    begin
        first_hit_next = '0;
        for (int i = OAL_GROUP - 1; i >= 0; i--)
        begin
            if (hits[i])
            begin
                first_hit_next = OAL_GROUP_BITS'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sel_data_reg  <= ents[sel];
        any_hit_reg   <= |hits;
        first_hit_reg <= first_hit_next;
    end

    assign sel_data  = sel_data_reg;
    assign any_hit   = any_hit_reg;
    assign first_hit = first_hit_reg;

endmodule

`default_nettype wire

// ===== design/ordered_array_list_engine_unit.sv =====
// Ordered array list engine: a chain of DEPTH cells with a count of entries.
// A request is accepted in S_IDLE and passes through S_GROUP and S_FINAL; the
// response is valid in S_OUT, and no new request is taken until it is taken.
// The two-level read/search tree and the output register set this sequence.
// Reset clears the entry count and the control state; cell contents are
// undefined until written by an insert and are never read before that.
`default_nettype none

module ordered_array_list_engine_unit
    import oal_pkg::*;
#(
    parameter int DEPTH = OAL_DEPTH
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    oal_req_if.sink     req,
    oal_rsp_if.source   rsp
);

    // Width of the entry count, of positions compared inside the chain,
    // and of the group index in the read/search tree.
    localparam int LW = $clog2(DEPTH + 1);
    localparam int PW = (LW > OAL_POS_W) ? LW : OAL_POS_W;
    localparam int GW = (DEPTH > OAL_GROUP) ?
                        $clog2((DEPTH + OAL_GROUP - 1) / OAL_GROUP) : 1;
    localparam int NG = 1 << GW;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_GROUP = 4'b0010,
        S_FINAL = 4'b0100,
        S_OUT   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Captured request.
    logic [2:0]         op_reg;
    logic [6:0]         pos_reg;
    logic signed [31:0] value_reg;
    logic [PW-1:0]      pos_ext;

    logic [LW-1:0]      length_reg;
    logic [LW-1:0]      length_next;

    // Response registers.
    status_t            status_reg;
    status_t            status_next;
    logic signed [31:0] data_reg;
    logic signed [31:0] data_next;
    logic [6:0]         found_reg;
    logic [6:0]         found_next;
    logic [7:0]         count_reg;

    cell_cmd_t          cmd;

    logic signed [31:0]              ent [DEPTH];
    logic                            cell_match [DEPTH];
    logic [NG-1:0][OAL_GROUP-1:0][31:0] pad_ent;
    logic [NG-1:0][OAL_GROUP-1:0]    pad_hit;

    logic signed [31:0]              grp_data [NG];
    logic [NG-1:0]                   grp_hit;
    logic [OAL_GROUP_BITS-1:0]       grp_first [NG];

    logic [GW-1:0]                   rd_grp;
    logic                            srch_hit;
    logic [GW+OAL_GROUP_BITS-1:0]    srch_idx;

    logic                            req_fire;
    logic                            rsp_fire;

    assign req_fire = req.valid && req.ready;
    assign rsp_fire = rsp.valid && rsp.ready;
    assign pos_ext  = PW'(pos_reg);

    // Request capture; payload only.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg    <= req.op;
            pos_reg   <= req.position;
            value_reg <= req.value;
        end
    end

    // Chain of cells; the outer neighbors are tied off.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [31:0] left_e;
        logic signed [31:0] right_e;

        if (i == 0)
        begin : g_first
            assign left_e = value_reg;
        end
        else
        begin : g_mid
            assign left_e = ent[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_e = ent[i];
        end
        else
        begin : g_inner
            assign right_e = ent[i+1];
        end

        oal_cell #(
            .IDX (i),
            .PW  (PW)
        ) u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .pos         (pos_ext),
            .key         (value_reg),
            .left_entry  (left_e),
            .right_entry (right_e),
            .entry       (ent[i]),
            .match       (cell_match[i])
        );
    end

    // Pad the chain to whole groups; only cells below the count may match.
    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            for (int k = 0; k < OAL_GROUP; k++)
            begin
                pad_ent[g][k] = '0;
                pad_hit[g][k] = 1'b0;
            end
        end
        for (int i = 0; i < DEPTH; i++)
        begin
            pad_ent[i / OAL_GROUP][i % OAL_GROUP] = ent[i];
            pad_hit[i / OAL_GROUP][i % OAL_GROUP] =
                cell_match[i] && (LW'(i) < length_reg);
        end
    end

    // First tree level, one stage per group of cells.
    for (genvar g = 0; g < NG; g++)
    begin : g_grp
        oal_group u_group (
            .clk       (clk),
            .ents      (pad_ent[g]),
            .hits      (pad_hit[g]),
            .sel       (pos_ext[OAL_GROUP_BITS-1:0]),
            .sel_data  (grp_data[g]),
            .any_hit   (grp_hit[g]),
            .first_hit (grp_first[g])
        );
    end

    // Second tree level: pick the read group and the first group with a hit.
    assign rd_grp = GW'(pos_ext >> OAL_GROUP_BITS);

    always_comb
    begin
        srch_hit = |grp_hit;
        srch_idx = '0;
        for (int g = NG - 1; g >= 0; g--)
        begin
            if (grp_hit[g])
            begin
                srch_idx = {GW'(g), grp_first[g]};
            end
        end
    end

    // Operation decode, active in the S_FINAL state of an item.
    always_comb
    begin
        cmd         = '0;
        length_next = length_reg;
        status_next = ST_OK;
        data_next   = '0;
        found_next  = '0;
        if (state_reg == S_FINAL)
        begin
            unique case (op_t'(op_reg))
                OP_CLEAR:
                begin
                    length_next = '0;
                end
                OP_INSERT:
                begin
                    priority if (length_reg == LW'(DEPTH))
                    begin
                        status_next = ST_FULL;
                    end
                    else if (pos_ext > PW'(length_reg))
                    begin
                        status_next = ST_BADPOS;
                    end
                    else
                    begin
                        cmd.do_insert = 1'b1;
                        length_next   = length_reg + LW'(1);
                    end
                end
                OP_DELETE:
                begin
                    if (pos_ext >= PW'(length_reg))
                    begin
                        status_next = ST_BADPOS;
                    end
                    else
                    begin
                        data_next     = grp_data[rd_grp];
                        cmd.do_delete = 1'b1;
                        length_next   = length_reg - LW'(1);
                    end
                end
                OP_SEARCH:
                begin
                    if (srch_hit)
                    begin
                        found_next = 7'(srch_idx);
                    end
                    else
                    begin
                        status_next = ST_NOTFND;
                    end
                end
                OP_READ:
                begin
                    if (pos_ext >= PW'(length_reg))
                    begin
                        status_next = ST_BADPOS;
                    end
                    else
                    begin
                        data_next = grp_data[rd_grp];
                    end
                end
                default:
                begin
                    length_next = length_reg;
                end
            endcase
        end
    end

    // Sequencer: capture, group stage, final stage, response.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_GROUP;
                end
            end
            S_GROUP:
            begin
                state_next = S_FINAL;
            end
            S_FINAL:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (rsp_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            length_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            length_reg <= length_next;
        end
    end

    // Response register, loaded at the end of the final stage.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_FINAL)
        begin
            status_reg <= status_next;
            data_reg   <= data_next;
            found_reg  <= found_next;
            count_reg  <= 8'(length_next);
        end
    end

    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = (state_reg == S_OUT);
    assign rsp.status         = status_reg;
    assign rsp.data           = data_reg;
    assign rsp.found_position = found_reg;
    assign rsp.count          = count_reg;

`ifndef SYNTHESIS
    // The entry count never passes the number of cells.
    a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
        length_reg <= LW'(DEPTH))
        else $error("entry count exceeds depth");

    // A pending response blocks new requests.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !req.ready)
        else $error("request accepted while response pending");

    // Every accepted request produces a response after the S_GROUP and S_FINAL states.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> ##2 rsp.valid)
        else $error("response not presented on time");

    // The chain shifts only in the final stage, never both ways at once.
    a_cmd_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.do_insert || cmd.do_delete) |->
            ((state_reg == S_FINAL) && !(cmd.do_insert && cmd.do_delete)))
        else $error("illegal cell command");
`endif

endmodule

`default_nettype wire
